### rtl/hex_label_assembler_unit_macros.svh
// Assertion macros shared by the checker of the hex label assembler.
// No dependencies; included by files that hold concurrent assertions.
`ifndef HEX_LABEL_ASSEMBLER_UNIT_MACROS_SVH
`define HEX_LABEL_ASSEMBLER_UNIT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define HLA_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define HLA_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
		else $error(msg);

`endif

### rtl/hla_pkg.sv
// Package of the hex label assembler: opcodes, scan modes, character codes,
// the digit decoder and the label memory control struct. No dependencies.
`default_nettype none

package hla_pkg;

	localparam logic [1:0] OP_PASS1 = 2'd0;
	localparam logic [1:0] OP_PASS2 = 2'd1;
	localparam logic [1:0] OP_START = 2'd2;

	localparam logic [1:0] MODE_NORMAL  = 2'd0;
	localparam logic [1:0] MODE_COMMENT = 2'd1;
	localparam logic [1:0] MODE_LABEL   = 2'd2;
	localparam logic [1:0] MODE_POINTER = 2'd3;

	localparam logic [7:0] CH_LF      = 8'd10;
	localparam logic [7:0] CH_CR      = 8'd13;
	localparam logic [7:0] CH_HASH    = 8'd35;
	localparam logic [7:0] CH_ZERO    = 8'd48;
	localparam logic [7:0] CH_NINE    = 8'd57;
	localparam logic [7:0] CH_COLON   = 8'd58;
	localparam logic [7:0] CH_SEMI    = 8'd59;
	localparam logic [7:0] CH_AT      = 8'd64;
	localparam logic [7:0] CH_UPPER_A = 8'd65;
	localparam logic [7:0] CH_UPPER_Z = 8'd90;
	localparam logic [7:0] CH_LOWER_A = 8'd97;
	localparam logic [7:0] CH_LOWER_Z = 8'd122;
	localparam logic [7:0] UPPER_OFS  = 8'd55;
	localparam logic [7:0] LOWER_OFS  = 8'd87;

	localparam int LABEL_COUNT = 256;
	localparam int LABEL_IDX_W = 8;

	typedef struct packed {
		logic                   ok;
		logic [5:0]             val;
	} digit_t;

	typedef struct packed {
		logic                   wr_en;
		logic [LABEL_IDX_W-1:0] wr_idx;
		logic                   rd_en;
		logic [LABEL_IDX_W-1:0] rd_idx;
	} mem_ctl_t;

	function automatic digit_t digit_of(input logic [7:0] c);
		digit_t r;
		logic [7:0] v;
		r.ok = 1'b1;
		v    = 8'd0;
		if (c inside {[CH_ZERO:CH_NINE]}) begin
			v = c - CH_ZERO;
		end else if (c inside {[CH_LOWER_A:CH_LOWER_Z]}) begin
			v = c - LOWER_OFS;
		end else if (c inside {[CH_UPPER_A:CH_UPPER_Z]}) begin
			v = c - UPPER_OFS;
		end else begin
			r.ok = 1'b0;
		end
		r.val = v[5:0];
		return r;
	endfunction

endpackage

`default_nettype wire

### rtl/hla_label_mem.sv
// Label table: one synchronous RAM with a registered read port and
// per-entry valid flops so that unwritten labels read as zero. Uses hla_pkg.
`default_nettype none

module hla_label_mem
	import hla_pkg::*;
#(
	parameter int DATA_W = 16
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire mem_ctl_t          ctl,
	input  wire logic [DATA_W-1:0] wr_data,
	output logic      [DATA_W-1:0] rd_data
);

	logic [DATA_W-1:0]      mem [LABEL_COUNT];
	logic [LABEL_COUNT-1:0] valid_q;
	logic [DATA_W-1:0]      rd_q;
	logic                   rd_valid_q;

	always_ff @(posedge clk) begin
		if (ctl.wr_en) begin
			mem[ctl.wr_idx] <= wr_data;
		end
		if (ctl.rd_en) begin
			rd_q <= mem[ctl.rd_idx];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q    <= '0;
			rd_valid_q <= 1'b0;
		end else begin
			if (ctl.wr_en) begin
				valid_q[ctl.wr_idx] <= 1'b1;
			end
			if (ctl.rd_en) begin
				rd_valid_q <= valid_q[ctl.rd_idx];
			end
		end
	end

	assign rd_data = rd_valid_q ? rd_q : '0;

endmodule

`default_nettype wire

### rtl/hex_label_assembler_unit.sv
// Top level of the two-pass hex label assembler: scanner, result stage and
// output register. Uses hla_pkg and the label RAM in hla_label_mem.
//
// The block takes source text one byte per transaction on the slave stream,
// with tuser telling the pass (pass one, pass two, or start of a pass), and
// emits assembled bytes on the master stream, tlast marking the last byte
// that one input byte caused. Pass one records the byte address of every
// ":x" label; pass two turns digit pairs into bytes and "@x" into a 16-bit
// big-endian relative offset (label minus address plus two, two's
// complement). A stream is taken at one byte per clock as long as the
// master side keeps up and no pointer is being sent. A pointer in pass
// two produces two output transactions and holds the input until its low
// byte is loaded into the single output register, which moves one byte a
// cycle while the master side keeps up. The label table sits in one
// synchronous RAM read at the cycle a byte is accepted; its registered data
// is used in the next cycle by the result stage. Label entries come out of
// reset as zero through valid flops, so no clearing pass follows reset.
// Each result passes through the result stage and then the output register.
`default_nettype none

module hex_label_assembler_unit
	import hla_pkg::*;
#(
	parameter int ADDR_WIDTH = 16
) (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       s_tvalid,
	output logic            s_tready,
	input  wire logic [7:0] s_tdata,   // [7:0] ch
	input  wire logic [1:0] s_tuser,   // [1:0] op
	output logic            m_tvalid,
	input  wire logic       m_tready,
	output logic      [7:0] m_tdata,   // [7:0] out_byte
	output logic            m_tlast
);

	// Scanner state, updated at each accepted transaction.
	logic [ADDR_WIDTH-1:0] addr_q;
	logic                  odd_q;
	logic [5:0]            hn_q;
	logic [1:0]            mode_q;

	logic [ADDR_WIDTH-1:0] addr_d;
	logic                  odd_d;
	logic [5:0]            hn_d;
	logic [1:0]            mode_d;

	// Result stage: one pending byte or pointer.
	logic                  v_s1;
	logic                  ptr_s1;
	logic                  phase_q;
	logic [7:0]            byte_s1;
	logic [ADDR_WIDTH-1:0] addr_s1;

	// Output register.
	logic                  o_v_q;
	logic [7:0]            o_byte_q;
	logic                  o_last_q;

	logic                  accept;
	logic                  second;
	logic                  push;
	logic                  push_ptr;
	logic [7:0]            push_byte;
	digit_t                dig;
	mem_ctl_t              mem_ctl;
	logic [ADDR_WIDTH-1:0] target;
	logic [15:0]           tgt16;
	logic [15:0]           adr16;
	logic [15:0]           offset;
	logic [7:0]            beat_byte;
	logic                  beat_last;
	logic                  out_load;
	logic                  beat_move;

	assign second = (s_tuser == OP_PASS2);
	assign dig    = digit_of(s_tdata);

	// Scanner: decides the next state and whether this byte yields a result.
	always_comb begin
		addr_d      = addr_q;
		odd_d       = odd_q;
		hn_d        = hn_q;
		mode_d      = mode_q;
		push        = 1'b0;
		push_ptr    = 1'b0;
		push_byte   = {hn_q[3:0], 4'b0000} + {2'b00, dig.val};
		mem_ctl.wr_en  = 1'b0;
		mem_ctl.wr_idx = s_tdata;
		mem_ctl.rd_en  = accept;
		mem_ctl.rd_idx = s_tdata;
		if (s_tuser == OP_START) begin
			addr_d = '0;
			odd_d  = 1'b0;
			hn_d   = '0;
			mode_d = MODE_NORMAL;
		end else if (s_tuser == OP_PASS1 || s_tuser == OP_PASS2) begin
			case (mode_q)
				MODE_COMMENT: begin
					if (s_tdata == CH_LF || s_tdata == CH_CR) begin
						mode_d = MODE_NORMAL;
					end
				end
				MODE_LABEL: begin
					mode_d        = MODE_NORMAL;
					mem_ctl.wr_en = accept && !second;
				end
				MODE_POINTER: begin
					mode_d   = MODE_NORMAL;
					addr_d   = addr_q + ADDR_WIDTH'(2);
					push     = second;
					push_ptr = 1'b1;
				end
				default: begin
					if (s_tdata == CH_COLON) begin
						mode_d = MODE_LABEL;
					end else if (s_tdata == CH_AT) begin
						mode_d = MODE_POINTER;
					end else if (s_tdata == CH_HASH || s_tdata == CH_SEMI) begin
						mode_d = MODE_COMMENT;
					end else if (dig.ok) begin
						if (odd_q) begin
							odd_d  = 1'b0;
							addr_d = addr_q + ADDR_WIDTH'(1);
							if (second) begin
								hn_d = '0;
								push = 1'b1;
							end
						end else begin
							odd_d = 1'b1;
							if (second) begin
								hn_d = dig.val;
							end
						end
					end
				end
			endcase
		end
	end

	hla_label_mem #(
		.DATA_W (ADDR_WIDTH)
	) u_mem (
		.clk     (clk),
		.arst_n  (arst_n),
		.ctl     (mem_ctl),
		.wr_data (addr_q),
		.rd_data (target)
	);

	// The offset is formed in 16 bits whatever the address width.
	generate
		if (ADDR_WIDTH >= 16) begin : g_trunc
			assign tgt16 = target[15:0];
			assign adr16 = addr_s1[15:0];
		end else begin : g_ext
			assign tgt16 = {{(16-ADDR_WIDTH){1'b0}}, target};
			assign adr16 = {{(16-ADDR_WIDTH){1'b0}}, addr_s1};
		end
	endgenerate

	assign offset = tgt16 - adr16 + 16'd4;

	// A pointer goes out as high byte, then low byte; a digit pair is one beat.
	assign beat_byte = ptr_s1 ? (phase_q ? offset[7:0] : offset[15:8]) : byte_s1;
	assign beat_last = !ptr_s1 || phase_q;
	assign out_load  = !o_v_q || m_tready;
	assign beat_move = v_s1 && out_load;
	assign s_tready  = !v_s1 || (beat_move && beat_last);
	assign accept    = s_tvalid && s_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			addr_q  <= '0;
			odd_q   <= 1'b0;
			hn_q    <= '0;
			mode_q  <= MODE_NORMAL;
			v_s1    <= 1'b0;
			phase_q <= 1'b0;
			o_v_q   <= 1'b0;
		end else begin
			if (accept) begin
				addr_q <= addr_d;
				odd_q  <= odd_d;
				hn_q   <= hn_d;
				mode_q <= mode_d;
			end
			if (accept) begin
				v_s1    <= push;
				phase_q <= 1'b0;
			end else if (beat_move) begin
				if (beat_last) begin
					v_s1 <= 1'b0;
				end
				phase_q <= 1'b1;
			end
			if (out_load) begin
				o_v_q <= v_s1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			ptr_s1  <= push_ptr;
			byte_s1 <= push_byte;
			addr_s1 <= addr_d;
		end
		if (beat_move) begin
			o_byte_q <= beat_byte;
			o_last_q <= beat_last;
		end
	end

	assign m_tvalid = o_v_q;
	assign m_tdata  = o_byte_q;
	assign m_tlast  = o_last_q;

endmodule

`default_nettype wire

### rtl/hla_checker.sv
// Port-level checker of the hex label assembler and its bind to the top.
// Uses the macros in hex_label_assembler_unit_macros.svh.
`default_nettype none
`include "hex_label_assembler_unit_macros.svh"

module hla_checker (
	input wire logic       clk,
	input wire logic       arst_n,
	input wire logic       s_tvalid,
	input wire logic       s_tready,
	input wire logic       m_tvalid,
	input wire logic       m_tready,
	input wire logic [7:0] m_tdata,
	input wire logic       m_tlast
);

	// A stalled output transaction keeps its payload.
	`HLA_ASSERT_NEXT(a_out_hold, clk, arst_n, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata) && $stable(m_tlast), "output changed while stalled")

	// The high byte of a pointer is followed at once by its low byte.
	`HLA_ASSERT_NEXT(a_ptr_pair, clk, arst_n, m_tvalid && m_tready && !m_tlast, m_tvalid && m_tlast, "pointer low byte missing")

	// A fresh result on the output must follow an accepted input transaction.
	`HLA_ASSERT_NOW(a_out_cause, clk, arst_n, m_tvalid && !$past(m_tvalid), $past(s_tvalid && s_tready, 2), "result without a causing input")

endmodule

bind hex_label_assembler_unit hla_checker u_hla_checker (.*);

`default_nettype wire
